// ----- src/utvf_pkg.sv -----
package utvf_pkg;

	// Status codes reported at the end of a field.
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_EMPTY   = 2'd1;
	localparam logic [1:0] STATUS_BAD_ENC = 2'd2;
	localparam logic [1:0] STATUS_CONTROL = 2'd3;

	// Allowed ranges for the next continuation byte.
	localparam logic [2:0] WIN_NORMAL = 3'd0;
	localparam logic [2:0] WIN_A0_BF  = 3'd1;
	localparam logic [2:0] WIN_80_9F  = 3'd2;
	localparam logic [2:0] WIN_90_BF  = 3'd3;
	localparam logic [2:0] WIN_80_8F  = 3'd4;

	// Byte values that bound the lead and continuation ranges.
	localparam logic [7:0] BYTE_CONT_LO  = 8'h80;
	localparam logic [7:0] BYTE_CONT_HI  = 8'hBF;
	localparam logic [7:0] BYTE_LEAD2_LO = 8'hC2;
	localparam logic [7:0] BYTE_LEAD2_HI = 8'hDF;
	localparam logic [7:0] BYTE_LEAD3_LO = 8'hE0;
	localparam logic [7:0] BYTE_LEAD3_HI = 8'hEF;
	localparam logic [7:0] BYTE_SURR     = 8'hED;
	localparam logic [7:0] BYTE_LEAD4_LO = 8'hF0;
	localparam logic [7:0] BYTE_LEAD4_HI = 8'hF4;
	localparam logic [7:0] BYTE_A0       = 8'hA0;
	localparam logic [7:0] BYTE_9F       = 8'h9F;
	localparam logic [7:0] BYTE_90       = 8'h90;
	localparam logic [7:0] BYTE_8F       = 8'h8F;
	localparam logic [7:0] BYTE_SPACE    = 8'h20;
	localparam logic [7:0] BYTE_DEL      = 8'h7F;

	// One item held in the input stage and handed to the field checker.
	typedef struct packed {
		logic       valid;
		logic [7:0] char_byte;
		logic       end_of_string;
	} item_t;

endpackage

// ----- src/utvf_field_check.sv -----
module utvf_field_check (
	input  logic             clk,
	input  logic             arst_n,
	input  utvf_pkg::item_t  item,
	input  logic             advance,
	output logic [1:0]       status
);

	logic       seen_q;
	logic [1:0] expected_q;
	logic [2:0] window_q;
	logic       enc_err_q;
	logic       ctl_err_q;

	logic [7:0] lo;
	logic [7:0] hi;
	logic       in_win;
	logic       is_ctl;
	logic       step;

	// Bounds of the current continuation window.
	always_comb begin
		lo = utvf_pkg::BYTE_CONT_LO;
		hi = utvf_pkg::BYTE_CONT_HI;
		unique case (window_q)
			utvf_pkg::WIN_A0_BF: lo = utvf_pkg::BYTE_A0;
			utvf_pkg::WIN_80_9F: hi = utvf_pkg::BYTE_9F;
			utvf_pkg::WIN_90_BF: lo = utvf_pkg::BYTE_90;
			utvf_pkg::WIN_80_8F: hi = utvf_pkg::BYTE_8F;
			default: ;
		endcase
	end

	assign in_win = (item.char_byte >= lo) && (item.char_byte <= hi);
	assign is_ctl = (item.char_byte < utvf_pkg::BYTE_SPACE) ||
		(item.char_byte == utvf_pkg::BYTE_DEL);
	assign step = item.valid && advance;

	// Status of the field as it stands, in priority order.
	always_comb begin
		if (!seen_q) begin
			status = utvf_pkg::STATUS_EMPTY;
		end else if (enc_err_q || (expected_q != 2'd0)) begin
			status = utvf_pkg::STATUS_BAD_ENC;
		end else if (ctl_err_q) begin
			status = utvf_pkg::STATUS_CONTROL;
		end else begin
			status = utvf_pkg::STATUS_OK;
		end
	end

	// Per-byte state update; the terminator returns everything to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= 1'b0;
			expected_q <= 2'd0;
			window_q   <= utvf_pkg::WIN_NORMAL;
			enc_err_q  <= 1'b0;
			ctl_err_q  <= 1'b0;
		end else if (step) begin
			if (item.end_of_string) begin
				seen_q     <= 1'b0;
				expected_q <= 2'd0;
				window_q   <= utvf_pkg::WIN_NORMAL;
				enc_err_q  <= 1'b0;
				ctl_err_q  <= 1'b0;
			end else begin
				seen_q <= 1'b1;
				if (is_ctl) begin
					ctl_err_q <= 1'b1;
				end
				if (expected_q != 2'd0) begin
					// Continuation byte of an open sequence.
					window_q <= utvf_pkg::WIN_NORMAL;
					if (in_win) begin
						expected_q <= expected_q - 2'd1;
					end else begin
						expected_q <= 2'd0;
						enc_err_q  <= 1'b1;
					end
				end else if (item.char_byte < utvf_pkg::BYTE_CONT_LO) begin
					// Plain ASCII byte leaves the sequence state alone.
				end else if ((item.char_byte >= utvf_pkg::BYTE_LEAD2_LO) &&
						(item.char_byte <= utvf_pkg::BYTE_LEAD2_HI)) begin
					expected_q <= 2'd1;
					window_q   <= utvf_pkg::WIN_NORMAL;
				end else if ((item.char_byte >= utvf_pkg::BYTE_LEAD3_LO) &&
						(item.char_byte <= utvf_pkg::BYTE_LEAD3_HI)) begin
					expected_q <= 2'd2;
					if (item.char_byte == utvf_pkg::BYTE_LEAD3_LO) begin
						window_q <= utvf_pkg::WIN_A0_BF;
					end else if (item.char_byte == utvf_pkg::BYTE_SURR) begin
						window_q <= utvf_pkg::WIN_80_9F;
					end else begin
						window_q <= utvf_pkg::WIN_NORMAL;
					end
				end else if ((item.char_byte >= utvf_pkg::BYTE_LEAD4_LO) &&
						(item.char_byte <= utvf_pkg::BYTE_LEAD4_HI)) begin
					expected_q <= 2'd3;
					if (item.char_byte == utvf_pkg::BYTE_LEAD4_LO) begin
						window_q <= utvf_pkg::WIN_90_BF;
					end else if (item.char_byte == utvf_pkg::BYTE_LEAD4_HI) begin
						window_q <= utvf_pkg::WIN_80_8F;
					end else begin
						window_q <= utvf_pkg::WIN_NORMAL;
					end
				end else begin
					// Stray continuation or out-of-range lead byte.
					enc_err_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ----- src/utvf_result_reg.sv -----
module utvf_result_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  logic [1:0] status,
	output logic       free,
	output logic       status_valid,
	input  logic       status_ready,
	output logic [1:0] status_code
);

	logic       valid_q;
	logic [1:0] code_q;

	// The slot can take a new status when empty or when its transfer completes.
	assign free = !valid_q || status_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			code_q <= status;
		end
	end

	assign status_valid = valid_q;
	assign status_code  = code_q;

endmodule

// ----- src/utf8_text_field_validator_unit.sv -----
// Strict UTF-8 and control-character check of a text field delivered one
// byte per transfer and closed by a terminator transfer (end_of_string high).
// Byte transfers are taken back to back unless the input stalls; only the
// terminator yields a result, one status_code, which passes through the input
// register and then the result register. Codes: 0 ok, 1 empty, 2 invalid
// UTF-8 (including a sequence cut off at the end), 3 control byte. The
// input stalls only while a terminator waits behind a status that has not
// yet been taken; a field's state clears at its terminator.
module utf8_text_field_validator_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_ready,
	input  logic [7:0] char_byte,
	input  logic       end_of_string,
	output logic       status_valid,
	input  logic       status_ready,
	output logic [1:0] status_code
);

	utvf_pkg::item_t item_s1;
	logic            advance;
	logic            out_free;
	logic [1:0]      status;

	// A byte always moves on; a terminator needs room in the result register.
	assign advance    = !item_s1.end_of_string || out_free;
	assign char_ready = !item_s1.valid || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (char_ready) begin
			item_s1.valid         <= char_valid;
			item_s1.char_byte     <= char_byte;
			item_s1.end_of_string <= end_of_string;
		end
	end

	utvf_field_check u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_s1),
		.advance (advance),
		.status  (status)
	);

	utvf_result_reg u_result (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (item_s1.valid && item_s1.end_of_string),
		.status       (status),
		.free         (out_free),
		.status_valid (status_valid),
		.status_ready (status_ready),
		.status_code  (status_code)
	);

endmodule

// ----- src/utvf_checker.sv -----
module utvf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       char_ready,
	input logic       status_valid,
	input logic       status_ready,
	input logic [1:0] status_code
);

	// A pending status holds until its transfer.
	a_status_hold: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid && !status_ready |=> status_valid && $stable(status_code))
		else $error("status changed while stalled");

	// The input only stalls behind a status that is waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!char_ready |-> status_valid)
		else $error("input stalled with no pending status");

	// While the result slot is empty or being emptied, the input is open.
	a_open_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!status_valid || status_ready |-> char_ready)
		else $error("input stalled while the result slot could take a status");

	// A new status follows a cycle in which the input was open.
	a_rise_after_open: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(status_valid) |-> $past(char_ready))
		else $error("status appeared after a stalled cycle");

endmodule

bind utf8_text_field_validator_unit utvf_checker u_utvf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.char_ready   (char_ready),
	.status_valid (status_valid),
	.status_ready (status_ready),
	.status_code  (status_code)
);

// ----- tb/tb_utf8_text_field_validator_unit.sv -----
`timescale 1ns / 100ps

module tb_utf8_text_field_validator_unit;

	// One row of the directed stimulus table. Terminator rows carry the
	// status that the row is expected to produce.
	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_string;
		logic       typed;
		logic [1:0] typed_status;
	} dir_row_t;

	localparam int NUM_DIRECTED = 25;
	localparam int NUM_RANDOM   = 1650;
	localparam int QUIET_TAIL   = 200;

	localparam dir_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
		'{8'h00, 1'b1, 1'b1, utvf_pkg::STATUS_EMPTY},
		'{8'h41, 1'b0, 1'b0, utvf_pkg::STATUS_OK},
		'{8'hFF, 1'b1, 1'b1, utvf_pkg::STATUS_OK},
		'{8'h00, 1'b0, 1'b0, utvf_pkg::STATUS_OK},
		'{8'h00, 1'b1, 1'b1, utvf_pkg::STATUS_CONTROL},
		'{8'h7F, 1'b0, 1'b0, utvf_pkg::STATUS_OK},
		'{8'h7F, 1'b1, 1'b1, utvf_pkg::STATUS_CONTROL},
		'{8'hFF, 1'b0, 1'b0, utvf_pkg::STATUS_OK},
		'{8'h00, 1'b1, 1'b1, utvf_pkg::STATUS_BAD_ENC},
		'{8'hF4, 1'b0, 1'b0, utvf_pkg::STATUS_OK},
		'{8'h8F, 1'b0, 1'b0, utvf_pkg::STATUS_OK},
		'{8'hBF, 1'b0, 1'b0, utvf_pkg::STATUS_OK},
		'{8'hBF, 1'b0, 1'b0, utvf_pkg::STATUS_OK},
		'{8'h00, 1'b1, 1'b1, utvf_pkg::STATUS_OK},
		'{8'hE0, 1'b0, 1'b0, utvf_pkg::STATUS_OK},
		'{8'h9F, 1'b0, 1'b0, utvf_pkg::STATUS_OK},
		'{8'h00, 1'b1, 1'b1, utvf_pkg::STATUS_BAD_ENC},
		'{8'hED, 1'b0, 1'b0, utvf_pkg::STATUS_OK},
		'{8'hA0, 1'b0, 1'b0, utvf_pkg::STATUS_OK},
		'{8'h00, 1'b1, 1'b1, utvf_pkg::STATUS_BAD_ENC},
		'{8'hC2, 1'b0, 1'b0, utvf_pkg::STATUS_OK},
		'{8'h00, 1'b1, 1'b1, utvf_pkg::STATUS_BAD_ENC},
		'{8'hE2, 1'b0, 1'b0, utvf_pkg::STATUS_OK},
		'{8'h00, 1'b0, 1'b0, utvf_pkg::STATUS_OK},
		'{8'h00, 1'b1, 1'b1, utvf_pkg::STATUS_BAD_ENC}
	};

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       char_valid    = 1'b0;
	logic       char_ready;
	logic [7:0] char_byte     = 8'h00;
	logic       end_of_string = 1'b0;
	logic       status_valid;
	logic       status_ready  = 1'b0;
	logic [1:0] status_code;

	// Predicted state of the field checker.
	logic       field_seen;
	logic [1:0] field_owed;
	logic [2:0] field_window;
	logic       field_bad_enc;
	logic       field_ctrl;

	logic [1:0] expected_status[$];
	logic [7:0] field_bytes[$];
	int         mismatch_count = 0;
	int         items_sent     = 0;
	bit         idling_on      = 1'b1;

	utf8_text_field_validator_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_ready   (char_ready),
		.char_byte    (char_byte),
		.end_of_string(end_of_string),
		.status_valid (status_valid),
		.status_ready (status_ready),
		.status_code  (status_code)
	);

	always #5 clk = ~clk;

	initial begin
		#5ms;
		$display("*** FAILED ***");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// Bounds of a continuation window; unused codes fall back to 80-BF.
	function automatic void window_bounds(input logic [2:0] win,
			output logic [7:0] lo, output logic [7:0] hi);
		lo = utvf_pkg::BYTE_CONT_LO;
		hi = utvf_pkg::BYTE_CONT_HI;
		case (win)
			utvf_pkg::WIN_A0_BF: lo = utvf_pkg::BYTE_A0;
			utvf_pkg::WIN_80_9F: hi = utvf_pkg::BYTE_9F;
			utvf_pkg::WIN_90_BF: lo = utvf_pkg::BYTE_90;
			utvf_pkg::WIN_80_8F: hi = utvf_pkg::BYTE_8F;
			default: ;
		endcase
	endfunction

	// Window that applies to the first continuation after a lead byte.
	function automatic logic [2:0] lead_window(input logic [7:0] lead);
		case (lead)
			utvf_pkg::BYTE_LEAD3_LO: return utvf_pkg::WIN_A0_BF;
			utvf_pkg::BYTE_SURR:     return utvf_pkg::WIN_80_9F;
			utvf_pkg::BYTE_LEAD4_LO: return utvf_pkg::WIN_90_BF;
			utvf_pkg::BYTE_LEAD4_HI: return utvf_pkg::WIN_80_8F;
			default:                 return utvf_pkg::WIN_NORMAL;
		endcase
	endfunction

	function automatic void clear_field();
		field_seen    = 1'b0;
		field_owed    = 2'd0;
		field_window  = utvf_pkg::WIN_NORMAL;
		field_bad_enc = 1'b0;
		field_ctrl    = 1'b0;
	endfunction

	// Advances the predicted field state by one transfer and returns the
	// status it yields; the status only means something on a terminator.
	function automatic logic [1:0] field_step(input logic [7:0] b, input logic eos);
		logic [1:0] code;
		logic [7:0] lo;
		logic [7:0] hi;
		code = utvf_pkg::STATUS_OK;
		if (eos) begin
			if (!field_seen)
				code = utvf_pkg::STATUS_EMPTY;
			else if (field_bad_enc || field_owed != 2'd0)
				code = utvf_pkg::STATUS_BAD_ENC;
			else if (field_ctrl)
				code = utvf_pkg::STATUS_CONTROL;
			clear_field();
			return code;
		end
		field_seen = 1'b1;
		if (b < utvf_pkg::BYTE_SPACE || b == utvf_pkg::BYTE_DEL)
			field_ctrl = 1'b1;
		if (field_owed != 2'd0) begin
			window_bounds(field_window, lo, hi);
			if (b >= lo && b <= hi) begin
				field_owed = field_owed - 2'd1;
			end else begin
				field_bad_enc = 1'b1;
				field_owed    = 2'd0;
			end
			field_window = utvf_pkg::WIN_NORMAL;
		end else if (b >= utvf_pkg::BYTE_CONT_LO) begin
			if (b >= utvf_pkg::BYTE_LEAD2_LO && b <= utvf_pkg::BYTE_LEAD2_HI) begin
				field_owed   = 2'd1;
				field_window = utvf_pkg::WIN_NORMAL;
			end else if (b >= utvf_pkg::BYTE_LEAD3_LO && b <= utvf_pkg::BYTE_LEAD3_HI) begin
				field_owed   = 2'd2;
				field_window = lead_window(b);
			end else if (b >= utvf_pkg::BYTE_LEAD4_LO && b <= utvf_pkg::BYTE_LEAD4_HI) begin
				field_owed   = 2'd3;
				field_window = lead_window(b);
			end else begin
				field_bad_enc = 1'b1;
			end
		end
		return code;
	endfunction

	// Presents one item, waits for its transfer, records the expected status
	// of a terminator, and sometimes leaves a gap afterwards.
	task automatic send_item(input logic [7:0] b, input logic eos,
			input logic typed, input logic [1:0] typed_status);
		logic [1:0] code;
		char_valid    <= 1'b1;
		char_byte     <= b;
		end_of_string <= eos;
		do @(posedge clk); while (!char_ready);
		code = field_step(b, eos);
		if (eos)
			expected_status.push_back(typed ? typed_status : code);
		if (idling_on && $urandom_range(0, 4) == 0) begin
			char_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	// Holds the input idle until every expected status has arrived.
	task automatic drain_results();
		char_valid <= 1'b0;
		while (expected_status.size() != 0)
			@(posedge clk);
	endtask

	// Continuation byte inside a window, often on one of its edges.
	function automatic logic [7:0] pick_cont(input logic [2:0] win);
		logic [7:0] lo;
		logic [7:0] hi;
		window_bounds(win, lo, hi);
		case ($urandom_range(0, 3))
			0: return lo;
			1: return hi;
			default: return 8'($urandom_range(hi, lo));
		endcase
	endfunction

	// Appends one well-formed character, or now and then a control byte.
	function automatic void append_char();
		logic [7:0] lead;
		case ($urandom_range(0, 3))
			0: begin
				if ($urandom_range(0, 9) == 0)
					field_bytes.push_back($urandom_range(0, 1) ? utvf_pkg::BYTE_DEL :
						8'($urandom_range(0, 31)));
				else
					field_bytes.push_back(8'($urandom_range(32, 126)));
			end
			1: begin
				field_bytes.push_back(8'($urandom_range(utvf_pkg::BYTE_LEAD2_HI,
					utvf_pkg::BYTE_LEAD2_LO)));
				field_bytes.push_back(pick_cont(utvf_pkg::WIN_NORMAL));
			end
			2: begin
				case ($urandom_range(0, 3))
					0: lead = utvf_pkg::BYTE_LEAD3_LO;
					1: lead = utvf_pkg::BYTE_SURR;
					default: lead = 8'($urandom_range(utvf_pkg::BYTE_LEAD3_HI,
						utvf_pkg::BYTE_LEAD3_LO));
				endcase
				field_bytes.push_back(lead);
				field_bytes.push_back(pick_cont(lead_window(lead)));
				field_bytes.push_back(pick_cont(utvf_pkg::WIN_NORMAL));
			end
			default: begin
				case ($urandom_range(0, 3))
					0: lead = utvf_pkg::BYTE_LEAD4_LO;
					1: lead = utvf_pkg::BYTE_LEAD4_HI;
					default: lead = 8'($urandom_range(utvf_pkg::BYTE_LEAD4_HI,
						utvf_pkg::BYTE_LEAD4_LO));
				endcase
				field_bytes.push_back(lead);
				field_bytes.push_back(pick_cont(lead_window(lead)));
				field_bytes.push_back(pick_cont(utvf_pkg::WIN_NORMAL));
				field_bytes.push_back(pick_cont(utvf_pkg::WIN_NORMAL));
			end
		endcase
	endfunction

	// Builds one field: mostly well-formed text, sometimes damaged by a
	// replaced byte, an inserted byte or a cut-off tail.
	function automatic void build_field();
		int n_chars;
		int pos;
		field_bytes.delete();
		n_chars = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6);
		repeat (n_chars) append_char();
		case ($urandom_range(0, 9))
			0: if (field_bytes.size() != 0) begin
				pos = $urandom_range(0, field_bytes.size() - 1);
				field_bytes[pos] = 8'($urandom_range(0, 255));
			end
			1: if (field_bytes.size() != 0)
				void'(field_bytes.pop_back());
			2: begin
				pos = $urandom_range(0, field_bytes.size());
				field_bytes.insert(pos, 8'($urandom_range(0, 255)));
			end
			default: ;
		endcase
	endfunction

	// Status side: checks each result transfer and, while idling is on, stalls in random bursts.
	initial begin
		int stall_left;
		logic [1:0] want;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && status_valid && status_ready) begin
				if (expected_status.size() == 0) begin
					report_mismatch($sformatf("unexpected status %0d", status_code));
				end else begin
					want = expected_status.pop_front();
					if (status_code !== want)
						report_mismatch($sformatf("status_code %0d, expected %0d",
							status_code, want));
				end
			end
			if (!arst_n) begin
				status_ready <= 1'b0;
			end else if (idling_on && stall_left > 0) begin
				stall_left--;
				status_ready <= 1'b0;
			end else if (idling_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 9);
				status_ready <= 1'b0;
			end else begin
				status_ready <= 1'b1;
			end
		end
	end

	// Reset, directed table, random fields, then the final check.
	initial begin
		bit drained_mid;
		clear_field();
		drained_mid = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++)
			send_item(DIRECTED_ROWS[i].char_byte, DIRECTED_ROWS[i].end_of_string,
				DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].typed_status);
		drain_results();

		while (items_sent < NUM_RANDOM) begin
			if (items_sent >= NUM_RANDOM - QUIET_TAIL)
				idling_on = 1'b0;
			else if ($urandom_range(0, 7) == 0)
				idling_on = !idling_on;
			if (!drained_mid && items_sent >= NUM_RANDOM / 2) begin
				drain_results();
				drained_mid = 1'b1;
			end
			build_field();
			foreach (field_bytes[i]) begin
				send_item(field_bytes[i], 1'b0, 1'b0, utvf_pkg::STATUS_OK);
				items_sent++;
			end
			// The byte lane of a terminator is ignored, so it carries noise.
			send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, utvf_pkg::STATUS_OK);
			items_sent++;
		end
		char_valid <= 1'b0;

		while (expected_status.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && expected_status.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
